/* design/mng_pkg.sv */
// ============================================================================
// mng_pkg
// Shared types, widths and codes for the mesh normal generator.
// ============================================================================
`default_nettype none

package mng_pkg;

    // sizing defaults
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int FIFO_DEPTH       = 2;

    // field widths
    localparam int POS_W  = 20;
    localparam int IDX_W  = 16;
    localparam int DIF_W  = 21;
    localparam int MUL_W  = 25;
    localparam int PRD_W  = 2 * MUL_W;
    localparam int ACC_W  = 48;
    localparam int NRM_W  = 16;
    localparam int STS_W  = 3;
    localparam int SQ_W   = 98;
    localparam int ROOT_W = 49;
    localparam int NUM_W  = 63;
    localparam int Q_W    = 17;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_SHADING  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH_SQ = 1'd1;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STS_W-1:0] STS_FULL       = 3'd1;
    localparam logic [STS_W-1:0] STS_TRI_SKIP   = 3'd2;
    localparam logic [STS_W-1:0] STS_READ_RANGE = 3'd3;
    localparam logic [STS_W-1:0] STS_DEGENERATE = 3'd4;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TRI   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_DIFF,
        S_CROSS,
        S_ACC_RD,
        S_ACC_WR,
        S_RD,
        S_SQ,
        S_CHK,
        S_SQRT,
        S_DIV_GO,
        S_DIV
    } state_t;

endpackage

`default_nettype wire

/* design/mng_front.sv */
// ============================================================================
// mng_front
// Input side: accepts transactions, decodes the mode and queues the items.
// ============================================================================
`default_nettype none

module mng_front
    import mng_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              mode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [IDX_W-1:0]        index_a,
    input  wire logic [IDX_W-1:0]        index_b,
    input  wire logic [IDX_W-1:0]        index_c,
    output logic                         item_valid,
    output item_t                        item,
    input  wire logic                    item_pop
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t              fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push;
    item_t              in_item;

    // decode incoming transaction
    always_comb
    begin
        in_item.op      = op_t'(mode);
        in_item.pos_x   = pos_x;
        in_item.pos_y   = pos_y;
        in_item.pos_z   = pos_z;
        in_item.index_a = index_a;
        in_item.index_b = index_b;
        in_item.index_c = index_c;
    end

    assign in_ready   = (cnt_reg != CNT_W'(FIFO_DEPTH));
    assign push       = in_valid && in_ready;
    assign item_valid = (cnt_reg != '0);
    assign item       = fifo_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* design/mng_sqrt.sv */
// ============================================================================
// mng_sqrt
// Restoring integer square root, one root bit per cycle.
// ============================================================================
`default_nettype none

module mng_sqrt
    import mng_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TRY_W-1:0]  rem_sh;
    logic [TRY_W-1:0]  trial;
    logic              fits;

    // one trial subtraction
    assign rem_sh = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* design/mng_div.sv */
// ============================================================================
// mng_div
// Restoring divider for the normal scale, one quotient bit per cycle.
// The quotient is known to fit Q_W bits.
// ============================================================================
`default_nettype none

module mng_div
    import mng_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [ROOT_W-1:0] den,
    output logic                   done,
    output logic [Q_W-1:0]         quot
);

    localparam int D_W   = ROOT_W + Q_W - 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [D_W-1:0]   d_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;

    assign fits = ({{(D_W - NUM_W){1'b0}}, rem_reg} >= d_reg);
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            d_reg   <= {den, {(Q_W - 1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - NUM_W'(d_reg);
            end
            d_reg <= d_reg >> 1;
            q_reg <= {q_reg[Q_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* design/mng_back.sv */
// ============================================================================
// mng_back
// Execution side: vertex and accumulator stores, cross product and
// normalization sequencer, result register.
// ============================================================================
`default_nettype none

module mng_back
    import mng_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   flat_shading,
    input  wire logic [CFG_DATA_W-1:0]  min_length_sq,
    input  wire logic                   item_valid,
    input  wire item_t                  item,
    output logic                        item_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [STS_W-1:0]            status,
    output logic signed [NRM_W-1:0]     normal_x,
    output logic signed [NRM_W-1:0]     normal_y,
    output logic signed [NRM_W-1:0]     normal_z,
    output logic [CNT_W-1:0]            vertex_total
);

    localparam int ADR_W = $clog2(MAX_VERTICES);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W + 1 : IDX_W + 1;
    localparam int STP_W = 4;
    localparam int HLF_W = ACC_W / 2;

    // stores
    logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
    logic [3*POS_W-1:0] pos_q;
    logic [3*ACC_W-1:0] acc_q;

    // control
    state_t             state_reg, state_next;
    logic [STP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   count_reg;
    item_t              cur_reg;
    logic               res_valid_reg;
    logic               res_good_reg;
    logic [STS_W-1:0]   res_status_reg;

    // datapath registers
    logic [3*POS_W-1:0]       pa_reg, pb_reg, pc_reg;
    logic signed [DIF_W-1:0]  ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PRD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [ACC_W-1:0]         mag_reg [3];
    logic [2:0]               neg_reg;
    logic [SQ_W-1:0]          sum_reg;
    logic signed [NRM_W-1:0]  nrm_reg [3];

    // control outputs
    logic               fin;
    logic [STS_W-1:0]   fin_status;
    logic               fin_good;
    logic               pos_we, pos_re, acc_we, acc_re;
    logic [ADR_W-1:0]   pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [3*ACC_W-1:0] acc_wdata;
    logic               sqrt_start, div_start;

    // shared units
    logic               sqrt_done, div_done;
    logic [ROOT_W-1:0]  root;
    logic [Q_W-1:0]     quot;
    logic [NUM_W-1:0]   div_num;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] mul_p;

    // decode helpers
    logic               head_tri_ok, head_rd_ok, cur_tri_ok;
    logic               store_full;
    logic               degenerate;
    logic [IDX_W-1:0]   sel_idx;
    logic [1:0]         sq_comp, sq_part, acc_part;
    logic [ACC_W-1:0]   sq_mag;
    logic signed [ACC_W-1:0] ax, ay, az, cr_x, cr_y, cr_z;

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] cnt);
        idx_ok = (CMP_W'(idx) < CMP_W'(cnt));
    endfunction

    function automatic logic [1:0] comp_of(input logic [STP_W-1:0] s);
        case (s) inside
            4'd0, 4'd1, 4'd2: comp_of = 2'd0;
            4'd3, 4'd4, 4'd5: comp_of = 2'd1;
            default:          comp_of = 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] part_of(input logic [STP_W-1:0] s);
        case (s) inside
            4'd0, 4'd3, 4'd6: part_of = 2'd0;
            4'd1, 4'd4, 4'd7: part_of = 2'd1;
            default:          part_of = 2'd2;
        endcase
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end
        else
        begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [NRM_W-1:0] scale_sat(input logic [Q_W-1:0] q,
                                                         input logic neg);
        if (neg)
        begin
            scale_sat = (q >= Q_W'(1 << (NRM_W - 1))) ? {1'b1, {(NRM_W - 1){1'b0}}}
                                                       : NRM_W'(-q);
        end
        else
        begin
            scale_sat = (q > Q_W'((1 << (NRM_W - 1)) - 1)) ? {1'b0, {(NRM_W - 1){1'b1}}}
                                                           : NRM_W'(q);
        end
    endfunction

    // ---------------------------------------------------------------- decode
    assign store_full  = (count_reg == CNT_W'(MAX_VERTICES));
    assign head_tri_ok = idx_ok(item.index_a, count_reg) && idx_ok(item.index_b, count_reg)
                         && idx_ok(item.index_c, count_reg);
    assign head_rd_ok  = idx_ok(item.index_a, count_reg);
    assign cur_tri_ok  = 1'b1;
    assign degenerate  = (sum_reg[95:32] <= 64'(min_length_sq));

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    sel_idx = cur_reg.index_a;
            2'd1:    sel_idx = cur_reg.index_b;
            default: sel_idx = cur_reg.index_c;
        endcase
    end

    assign ax   = acc_q[3*ACC_W-1 -: ACC_W];
    assign ay   = acc_q[2*ACC_W-1 -: ACC_W];
    assign az   = acc_q[ACC_W-1:0];
    assign cr_x = flat_shading ? cx_reg : sat_add(ax, cx_reg);
    assign cr_y = flat_shading ? cy_reg : sat_add(ay, cy_reg);
    assign cr_z = flat_shading ? cz_reg : sat_add(az, cz_reg);

    // ------------------------------------------------------ shared multiplier
    assign sq_comp  = comp_of(step_reg);
    assign sq_part  = part_of(step_reg);
    assign acc_part = part_of(step_reg - 1'b1);
    assign sq_mag   = mag_reg[sq_comp];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                4'd0:    begin mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(vz_reg); end
                4'd1:    begin mul_a = MUL_W'(uz_reg); mul_b = MUL_W'(vy_reg); end
                4'd2:    begin mul_a = MUL_W'(uz_reg); mul_b = MUL_W'(vx_reg); end
                4'd3:    begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(vz_reg); end
                4'd4:    begin mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(vy_reg); end
                default: begin mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(vx_reg); end
            endcase
        end
        else
        begin
            case (sq_part)
                2'd0:    begin
                             mul_a = {1'b0, sq_mag[ACC_W-1:HLF_W]};
                             mul_b = {1'b0, sq_mag[ACC_W-1:HLF_W]};
                         end
                2'd1:    begin
                             mul_a = {1'b0, sq_mag[ACC_W-1:HLF_W]};
                             mul_b = {1'b0, sq_mag[HLF_W-1:0]};
                         end
                default: begin
                             mul_a = {1'b0, sq_mag[HLF_W-1:0]};
                             mul_b = {1'b0, sq_mag[HLF_W-1:0]};
                         end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // numerator of the scale: |acc| * 2^15 + len/2
    assign div_num = {mag_reg[step_reg[1:0]], {(NRM_W - 1){1'b0}}}
                     + NUM_W'(root >> 1);

    // ------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (item_valid && !res_valid_reg)
                begin
                    if (item.op == OP_TRI && head_tri_ok)
                    begin
                        state_next = S_POS;
                    end
                    else if (item.op == OP_READ && head_rd_ok)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_POS:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STP_W'(3))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                step_next  = '0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STP_W'(6))
                begin
                    step_next  = '0;
                    state_next = S_ACC_RD;
                end
            end
            S_ACC_RD:
            begin
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                step_next = step_reg + 1'b1;
                state_next = (step_reg == STP_W'(2)) ? S_IDLE : S_ACC_RD;
            end
            S_RD:
            begin
                step_next  = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STP_W'(9))
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = degenerate ? S_IDLE : S_SQRT;
            end
            S_SQRT:
            begin
                step_next = '0;
                if (sqrt_done)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = (step_reg == STP_W'(2)) ? S_IDLE : S_DIV_GO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        item_pop   = 1'b0;
        fin        = 1'b0;
        fin_status = STS_OK;
        fin_good   = 1'b0;
        pos_we     = 1'b0;
        pos_re     = 1'b0;
        acc_we     = 1'b0;
        acc_re     = 1'b0;
        pos_waddr  = count_reg[ADR_W-1:0];
        pos_raddr  = sel_idx[ADR_W-1:0];
        acc_waddr  = count_reg[ADR_W-1:0];
        acc_raddr  = sel_idx[ADR_W-1:0];
        acc_wdata  = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !res_valid_reg)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        OP_CLEAR:
                        begin
                            fin = 1'b1;
                        end
                        OP_LOAD:
                        begin
                            fin = 1'b1;
                            if (store_full)
                            begin
                                fin_status = STS_FULL;
                            end
                            else
                            begin
                                pos_we = 1'b1;
                                acc_we = 1'b1;
                            end
                        end
                        OP_TRI:
                        begin
                            if (!head_tri_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = STS_TRI_SKIP;
                            end
                        end
                        default:
                        begin
                            acc_raddr = item.index_a[ADR_W-1:0];
                            if (head_rd_ok)
                            begin
                                acc_re = 1'b1;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = STS_READ_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_POS:
            begin
                pos_re = (step_reg < STP_W'(3));
            end
            S_ACC_RD:
            begin
                acc_re = 1'b1;
            end
            S_ACC_WR:
            begin
                acc_we    = 1'b1;
                acc_waddr = sel_idx[ADR_W-1:0];
                acc_wdata = {cr_x, cr_y, cr_z};
                if (step_reg == STP_W'(2))
                begin
                    fin = cur_tri_ok;
                end
            end
            S_CHK:
            begin
                if (degenerate)
                begin
                    fin        = 1'b1;
                    fin_status = STS_DEGENERATE;
                end
                else
                begin
                    sqrt_start = 1'b1;
                end
            end
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                if (div_done && step_reg == STP_W'(2))
                begin
                    fin      = 1'b1;
                    fin_good = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_good_reg   <= 1'b0;
            res_status_reg <= STS_OK;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == S_IDLE && item_pop)
            begin
                if (item.op == OP_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (item.op == OP_LOAD && !store_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (fin)
            begin
                res_valid_reg  <= 1'b1;
                res_good_reg   <= fin_good;
                res_status_reg <= fin_status;
            end
            else if (res_valid_reg && out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------- datapath regs
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
        end

        // gather the three corner positions
        if (state_reg == S_POS)
        begin
            case (step_reg)
                4'd1:    pa_reg <= pos_q;
                4'd2:    pb_reg <= pos_q;
                4'd3:    pc_reg <= pos_q;
                default: begin end
            endcase
        end

        // edge vectors
        if (state_reg == S_DIFF)
        begin
            ux_reg <= DIF_W'($signed(pb_reg[59:40])) - DIF_W'($signed(pa_reg[59:40]));
            uy_reg <= DIF_W'($signed(pb_reg[39:20])) - DIF_W'($signed(pa_reg[39:20]));
            uz_reg <= DIF_W'($signed(pb_reg[19:0]))  - DIF_W'($signed(pa_reg[19:0]));
            vx_reg <= DIF_W'($signed(pc_reg[59:40])) - DIF_W'($signed(pa_reg[59:40]));
            vy_reg <= DIF_W'($signed(pc_reg[39:20])) - DIF_W'($signed(pa_reg[39:20]));
            vz_reg <= DIF_W'($signed(pc_reg[19:0]))  - DIF_W'($signed(pa_reg[19:0]));
        end

        if (state_reg == S_CROSS || state_reg == S_SQ)
        begin
            prod_reg <= mul_p;
        end

        // cross product terms, one product a cycle
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                4'd1:    cx_reg <= ACC_W'(prod_reg);
                4'd2:    cx_reg <= cx_reg - ACC_W'(prod_reg);
                4'd3:    cy_reg <= ACC_W'(prod_reg);
                4'd4:    cy_reg <= cy_reg - ACC_W'(prod_reg);
                4'd5:    cz_reg <= ACC_W'(prod_reg);
                4'd6:    cz_reg <= cz_reg - ACC_W'(prod_reg);
                default: begin end
            endcase
        end

        // magnitudes of the stored sum
        if (state_reg == S_RD)
        begin
            neg_reg    <= {az[ACC_W-1], ay[ACC_W-1], ax[ACC_W-1]};
            mag_reg[0] <= ax[ACC_W-1] ? ACC_W'(-ax) : ACC_W'(ax);
            mag_reg[1] <= ay[ACC_W-1] ? ACC_W'(-ay) : ACC_W'(ay);
            mag_reg[2] <= az[ACC_W-1] ? ACC_W'(-az) : ACC_W'(az);
            sum_reg    <= '0;
        end

        // squared length from partial products
        if (state_reg == S_SQ && step_reg != '0)
        begin
            case (acc_part)
                2'd0:    sum_reg <= sum_reg + (SQ_W'(prod_reg[ACC_W-1:0]) << ACC_W);
                2'd1:    sum_reg <= sum_reg + (SQ_W'(prod_reg[ACC_W-1:0]) << (HLF_W + 1));
                default: sum_reg <= sum_reg + SQ_W'(prod_reg[ACC_W-1:0]);
            endcase
        end

        if (state_reg == S_DIV && div_done)
        begin
            nrm_reg[step_reg[1:0]] <= scale_sat(quot, neg_reg[step_reg[1:0]]);
        end
    end

    // ----------------------------------------------------------------- stores
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= {item.pos_x, item.pos_y, item.pos_z};
        end
        if (pos_re)
        begin
            pos_q <= pos_mem[pos_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re)
        begin
            acc_q <= acc_mem[acc_raddr];
        end
    end

    // ---------------------------------------------------------- shared units
    mng_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    mng_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (root),
        .done  (div_done),
        .quot  (quot)
    );

    // result register
    assign out_valid    = res_valid_reg;
    assign status       = res_status_reg;
    assign normal_x     = res_good_reg ? nrm_reg[0] : '0;
    assign normal_y     = res_good_reg ? nrm_reg[1] : '0;
    assign normal_z     = res_good_reg ? nrm_reg[2] : '0;
    assign vertex_total = count_reg;

endmodule

`default_nettype wire

/* design/mesh_normal_generator.sv */
// ============================================================================
// mesh_normal_generator
// Per-vertex normal generation for a triangle mesh: area-weighted sums, or the last triangle under flat shading.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------
//   cfg      | in        | cfg_we                | cfg_index, cfg_data
//   in       | in        | in_valid / in_ready   | mode, pos_*, index_a/b/c
//   out      | out       | out_valid / out_ready | status, normal_*, total
//
// Clear, load and rejected items end at dispatch, which registers the result.
// A triangle reads three positions, forms six products on the shared
// multiplier and does three accumulator read-modify-writes. A read squares the
// stored sum, then runs the bit-serial square root and three divisions; a
// degenerate read ends at the length check. The back end holds while a result
// waits on out_ready, and a two-entry input queue keeps accepting until full.
// Reset clears the vertex count and resets the config; stores need no clearing.
// ============================================================================
`default_nettype none

module mesh_normal_generator
    import mng_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              mode,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [IDX_W-1:0]        index_a,
    input  wire logic [IDX_W-1:0]        index_b,
    input  wire logic [IDX_W-1:0]        index_c,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STS_W-1:0]             status,
    output logic signed [NRM_W-1:0]      normal_x,
    output logic signed [NRM_W-1:0]      normal_y,
    output logic signed [NRM_W-1:0]      normal_z,
    output logic [CNT_W-1:0]             vertex_total
);

    logic                  flat_shading_reg;
    logic [CFG_DATA_W-1:0] min_length_sq_reg;
    logic                  item_valid;
    logic                  item_pop;
    item_t                 item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_shading_reg  <= 1'b0;
            min_length_sq_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLAT_SHADING:  flat_shading_reg  <= cfg_data[0];
                CFG_MIN_LENGTH_SQ: min_length_sq_reg <= cfg_data;
                default:           begin end
            endcase
        end
    end

    mng_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    mng_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .CNT_W        (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .flat_shading  (flat_shading_reg),
        .min_length_sq (min_length_sq_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .vertex_total  (vertex_total)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_mesh_normal_generator.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_mesh_normal_generator
// Self-checking testbench for the mesh normal generator. A queue-fed driver
// sends clear, load, triangle and read transactions. An internal normal
// predictor computes the expected status, unit normal and vertex count. A
// monitor checks every result against the oldest prediction. The run covers
// several shading and length-threshold settings, random back-pressure, store
// overflow and accumulator saturation.
// ============================================================================
module tb_mesh_normal_generator;
    import mng_pkg::*;

    localparam int NVERT   = 1024;
    localparam int WD_MAX  = 20000;
    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        logic [STS_W-1:0]        status;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic [10:0]             total;
    } normal_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_FLAT_SHADING;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              mode = OP_CLEAR;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic [IDX_W-1:0]        index_a = '0;
    logic [IDX_W-1:0]        index_b = '0;
    logic [IDX_W-1:0]        index_c = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [STS_W-1:0]        status;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [10:0]             vertex_total;

    mesh_normal_generator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .index_a(index_a), .index_b(index_b), .index_c(index_c),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .vertex_total(vertex_total)
    );

    always #5 clk = ~clk;

    // predictor state
    longint      vtx_pos [NVERT][3];
    longint      acc_x [NVERT];
    longint      acc_y [NVERT];
    longint      acc_z [NVERT];
    int unsigned vtx_count = 0;
    bit          flat_mode = 1'b0;
    logic [31:0] min_len_sq = 32'd1;

    item_t       pending_items[$];
    normal_res_t expected_normals[$];
    int          snd_idle = 25;
    int          rcv_idle = 88;
    int          errors = 0;
    int          checked = 0;
    int          sent = 0;
    int          gen_count = 0;
    int          stalls = 0;
    int          n_degen = 0;
    int          n_ok_reads = 0;

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_HI) return ACC_HI;
        if (s < ACC_LO) return ACC_LO;
        return s;
    endfunction

    function automatic logic [127:0] square128(logic [63:0] m);
        logic [127:0] t;
        t = m;
        return t * t;
    endfunction

    function automatic logic signed [NRM_W-1:0] unit_comp(longint a, logic [63:0] len);
        logic [63:0] m;
        logic [63:0] q;
        m = (a < 0) ? -a : a;
        q = ((m << 15) + (len >> 1)) / len;
        if (a < 0) return (q >= 64'd32768) ? -16'sd32768 : -$signed(q[15:0]);
        return (q > 64'd32767) ? 16'sd32767 : q[15:0];
    endfunction

    // advance predictor state by one transaction and return its result
    function automatic normal_res_t predict_normal(item_t it);
        normal_res_t r;
        longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] sq;
        logic [63:0] root, cand;
        int ia, ib, ic;
        ia = it.index_a; ib = it.index_b; ic = it.index_c;
        r.status = STS_OK; r.nx = '0; r.ny = '0; r.nz = '0;
        case (it.op)
            OP_CLEAR: vtx_count = 0;
            OP_LOAD:
            begin
                if (vtx_count >= NVERT)
                    r.status = STS_FULL;
                else
                begin
                    vtx_pos[vtx_count][0] = it.pos_x;
                    vtx_pos[vtx_count][1] = it.pos_y;
                    vtx_pos[vtx_count][2] = it.pos_z;
                    acc_x[vtx_count] = 0;
                    acc_y[vtx_count] = 0;
                    acc_z[vtx_count] = 0;
                    vtx_count++;
                end
            end
            OP_TRI:
            begin
                if (ia >= vtx_count || ib >= vtx_count || ic >= vtx_count)
                    r.status = STS_TRI_SKIP;
                else
                begin
                    ux = vtx_pos[ib][0] - vtx_pos[ia][0];
                    uy = vtx_pos[ib][1] - vtx_pos[ia][1];
                    uz = vtx_pos[ib][2] - vtx_pos[ia][2];
                    vx = vtx_pos[ic][0] - vtx_pos[ia][0];
                    vy = vtx_pos[ic][1] - vtx_pos[ia][1];
                    vz = vtx_pos[ic][2] - vtx_pos[ia][2];
                    cx = uy * vz - uz * vy;
                    cy = uz * vx - ux * vz;
                    cz = ux * vy - uy * vx;
                    for (int k = 0; k < 3; k++)
                    begin
                        int v;
                        v = (k == 0) ? ia : (k == 1) ? ib : ic;
                        if (flat_mode)
                        begin
                            acc_x[v] = cx; acc_y[v] = cy; acc_z[v] = cz;
                        end
                        else
                        begin
                            acc_x[v] = sat_sum(acc_x[v], cx);
                            acc_y[v] = sat_sum(acc_y[v], cy);
                            acc_z[v] = sat_sum(acc_z[v], cz);
                        end
                    end
                end
            end
            default:
            begin
                if (ia >= vtx_count)
                    r.status = STS_READ_RANGE;
                else
                begin
                    sq = square128(acc_x[ia] < 0 ? -acc_x[ia] : acc_x[ia])
                       + square128(acc_y[ia] < 0 ? -acc_y[ia] : acc_y[ia])
                       + square128(acc_z[ia] < 0 ? -acc_z[ia] : acc_z[ia]);
                    if ((sq >> 32) <= {96'd0, min_len_sq})
                    begin
                        r.status = STS_DEGENERATE;
                        n_degen++;
                    end
                    else
                    begin
                        // floor square root, bit by bit
                        root = '0;
                        for (int b = 48; b >= 0; b--)
                        begin
                            cand = root | (64'd1 << b);
                            if (square128(cand) <= sq) root = cand;
                        end
                        r.nx = unit_comp(acc_x[ia], root);
                        r.ny = unit_comp(acc_y[ia], root);
                        r.nz = unit_comp(acc_z[ia], root);
                        n_ok_reads++;
                    end
                end
            end
        endcase
        r.total = vtx_count[10:0];
        return r;
    endfunction

    // driver: present next queued transaction, with random gaps
    always @(posedge clk)
    begin
        item_t nx_item;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_valid)
            begin
                expected_normals.insert(expected_normals.size(), predict_normal(
                    item_t'{op_t'(mode), pos_x, pos_y, pos_z, index_a, index_b, index_c}));
                sent++;
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle)
            begin
                nx_item = pending_items.pop_front();
                in_valid <= 1'b1;
                mode     <= nx_item.op;
                pos_x    <= nx_item.pos_x;
                pos_y    <= nx_item.pos_y;
                pos_z    <= nx_item.pos_z;
                index_a  <= nx_item.index_a;
                index_b  <= nx_item.index_b;
                index_c  <= nx_item.index_c;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: random back-pressure and result checking
    always @(posedge clk)
    begin
        normal_res_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_normals.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d", $time, status);
                    errors++;
                end
                else
                begin
                    e = expected_normals.pop_front();
                    checked++;
                    if (status !== e.status || normal_x !== e.nx || normal_y !== e.ny
                        || normal_z !== e.nz || vertex_total !== e.total)
                    begin
                        $display("%0t: mismatch expected sts=%0d n=(%0d,%0d,%0d) tot=%0d",
                                 $time, e.status, e.nx, e.ny, e.nz, e.total);
                        $display("%0t:          actual   sts=%0d n=(%0d,%0d,%0d) tot=%0d",
                                 $time, status, normal_x, normal_y, normal_z, vertex_total);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stalls <= 0;
        else if (stalls >= WD_MAX)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_normals.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stalls <= stalls + 1;
    end

    task automatic queue_item(op_t op, int x, int y, int z, int a, int b, int c);
        item_t it;
        it.op = op;
        it.pos_x = POS_W'(x); it.pos_y = POS_W'(y); it.pos_z = POS_W'(z);
        it.index_a = IDX_W'(a); it.index_b = IDX_W'(b); it.index_c = IDX_W'(c);
        pending_items.insert(pending_items.size(), it);
        if (op == OP_CLEAR) gen_count = 0;
        else if (op == OP_LOAD && gen_count < NVERT) gen_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FLAT_SHADING) flat_mode = val[0];
        else min_len_sq = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_normals.size() > 0 || in_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic int rand_index();
        if (gen_count > 0 && $urandom_range(99) < 88)
            return $urandom_range(gen_count - 1);
        return $urandom_range(16'hFFFF);
    endfunction

    // random coordinate: full range, extremes, or tiny
    function automatic int rand_coord();
        int s;
        s = $urandom_range(9);
        if (s == 0) return ($urandom_range(1)) ? 524287 : -524288;
        if (s <= 2) return $signed($urandom_range(8)) - 4;
        return $signed({$urandom_range(20'hFFFFF)} << 12) >>> 12;
    endfunction

    task automatic queue_random(int n);
        int p;
        queue_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            if (p < 3)
                queue_item(OP_CLEAR, rand_coord(), 0, 0, $urandom_range(16'hFFFF), 0, 0);
            else if (p < 28 || gen_count < 3)
                queue_item(OP_LOAD, rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(16'hFFFF), 0, 0);
            else if (p < 68)
                queue_item(OP_TRI, 0, 0, 0, rand_index(), rand_index(), rand_index());
            else
                queue_item(OP_READ, 0, 0, 0, rand_index(), $urandom_range(16'hFFFF), 0);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty mesh, extremes, skips, out-of-range and degenerate reads
        queue_item(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 0, 0, 0);
        queue_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD, -524288, -524288, -524288, 0, 0, 0);
        queue_item(OP_LOAD, 524287, -524288, 0, 0, 0, 0);
        queue_item(OP_LOAD, -524288, 524287, 524287, 0, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 0, 1, 2);
        queue_item(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 1, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 2, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 0, 1, 3);
        queue_item(OP_READ, 0, 0, 0, 3, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 16'hFFFF, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD, 1, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD, 0, 1, 0, 0, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 3, 4, 5);
        queue_item(OP_READ, 0, 0, 0, 3, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 0, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 1, 2, 0);
        queue_item(OP_READ, 0, 0, 0, 1, 0, 0);
        drain();

        // random phases over register settings and idle profiles
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_FLAT_SHADING, ph % 2);
            case (ph)
                0: write_reg(CFG_MIN_LENGTH_SQ, 32'd0);
                1: write_reg(CFG_MIN_LENGTH_SQ, 32'd1);
                2: write_reg(CFG_MIN_LENGTH_SQ, 32'hFFFF_FFFF);
                default: write_reg(CFG_MIN_LENGTH_SQ, 32'h0001_0000);
            endcase
            case (ph)
                0: begin snd_idle = 25; rcv_idle = 88; end
                1: begin snd_idle = 88; rcv_idle = 25; end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            queue_random(25);
            drain();
        end

        // fill the store, overflow it, and drive one vertex set into saturation
        write_reg(CFG_FLAT_SHADING, 1'b0);
        write_reg(CFG_MIN_LENGTH_SQ, 32'd1);
        snd_idle = 0; rcv_idle = 0;
        queue_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        queue_item(OP_LOAD, -524288, -524288, 524287, 0, 0, 0);
        queue_item(OP_LOAD, 524287, -524288, -524288, 0, 0, 0);
        queue_item(OP_LOAD, -524288, 524287, -524288, 0, 0, 0);
        while (gen_count < NVERT)
            queue_item(OP_LOAD, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
        queue_item(OP_LOAD, 1, 2, 3, 0, 0, 0);
        queue_item(OP_LOAD, -1, -2, -3, 0, 0, 0);
        for (int i = 0; i < 140; i++)
            queue_item(OP_TRI, 0, 0, 0, 0, 1, 2);
        queue_item(OP_READ, 0, 0, 0, 0, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 2, 0, 0);
        queue_item(OP_TRI, 0, 0, 0, 1023, 1022, 1021);
        queue_item(OP_READ, 0, 0, 0, 1023, 0, 0);
        queue_item(OP_READ, 0, 0, 0, 1024, 0, 0);
        drain();

        $display("Sent %0d transactions, checked %0d results (%0d unit normals, %0d degenerate).",
                 sent, checked, n_ok_reads, n_degen);
        $display("Covered smooth and flat shading, four length thresholds, store overflow.");
        if (errors == 0 && expected_normals.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
